>>> rtl/core/hsma_pkg.sv
// Shared types and constants of the handle slot map allocator.
// Depends on nothing; every other file of the block imports it.
package hsma_pkg;

    localparam int NUM_HANDLES = 256;
    localparam int POOL_DEPTH  = 256;
    localparam int NUM_KINDS   = 4;

    localparam int HANDLE_W = $clog2(NUM_HANDLES);
    localparam int SLOT_W   = $clog2(POOL_DEPTH);
    localparam int KIND_W   = (NUM_KINDS > 1) ? $clog2(NUM_KINDS) : 1;
    localparam int HCNT_W   = $clog2(NUM_HANDLES + 1);
    localparam int FILL_W   = $clog2(POOL_DEPTH + 1);
    localparam int OWN_AW   = KIND_W + SLOT_W;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 3;

    localparam logic [FUNC_W-1:0] FN_ACQUIRE = 2'd0;
    localparam logic [FUNC_W-1:0] FN_LOOKUP  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_DESTROY = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_RANGE    = 3'd1,
        ST_DEAD     = 3'd2,
        ST_MISMATCH = 3'd3,
        ST_NOHANDLE = 3'd4,
        ST_FULL     = 3'd5,
        ST_BADKIND  = 3'd6
    } status_t;

    // One row of the handle table. The free stack shares the rows: entry i of
    // the stack lives in the free_h field of row i.
    typedef struct packed {
        logic                live;
        logic [KIND_W-1:0]   kind;
        logic [SLOT_W-1:0]   slot;
        logic [HANDLE_W-1:0] free_h;
    } tbl_row_t;

    typedef struct packed {
        logic live;
        logic kind;
        logic slot;
        logic free_h;
    } tbl_mask_t;

    typedef struct packed {
        logic                rd_en;
        logic [HANDLE_W-1:0] rd_addr;
        tbl_mask_t           wr_mask;
        logic [HANDLE_W-1:0] wr_addr;
        tbl_row_t            wr_data;
    } tbl_req_t;

    typedef struct packed {
        logic                rd_en;
        logic [OWN_AW-1:0]   rd_addr;
        logic                wr_en;
        logic [OWN_AW-1:0]   wr_addr;
        logic [HANDLE_W-1:0] wr_data;
    } own_req_t;

    typedef struct packed {
        status_t             status;
        logic [HANDLE_W-1:0] handle;
        logic [SLOT_W-1:0]   slot;
        logic [KIND_W-1:0]   kind;
    } res_t;

endpackage

>>> rtl/core/hsma_cmd_if.sv
// Command channel of the handle slot map allocator: valid, ready and one word.
// Depends on hsma_pkg for the field widths.
interface hsma_cmd_if;
    import hsma_pkg::*;

    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [KIND_W-1:0]   shape_kind;
    logic [HANDLE_W-1:0] handle;

    modport source (output valid, output func, output shape_kind, output handle,
                    input ready);
    modport sink (input valid, input func, input shape_kind, input handle,
                  output ready);
endinterface

>>> rtl/core/hsma_rsp_if.sv
// Response channel of the handle slot map allocator: valid, ready and one word.
// Depends on hsma_pkg for the field widths.
interface hsma_rsp_if;
    import hsma_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle_out;
    logic [SLOT_W-1:0]   slot_offset;
    logic [KIND_W-1:0]   kind_out;

    modport source (output valid, output status, output handle_out,
                    output slot_offset, output kind_out, input ready);
    modport sink (input valid, input status, input handle_out,
                  input slot_offset, input kind_out, output ready);
endinterface

>>> rtl/core/hsma_tbl_mem.sv
// Handle table memory: live flag, kind and slot per handle, plus the free stack.
// One read and one field-masked write per cycle. Depends on hsma_pkg.
module hsma_tbl_mem (
    input  logic              clk,
    input  hsma_pkg::tbl_req_t req,
    output hsma_pkg::tbl_row_t rd_data
);
    import hsma_pkg::*;

    tbl_row_t mem [NUM_HANDLES];
    tbl_row_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_mask.live)
        begin
            mem[req.wr_addr].live <= req.wr_data.live;
        end
        if (req.wr_mask.kind)
        begin
            mem[req.wr_addr].kind <= req.wr_data.kind;
        end
        if (req.wr_mask.slot)
        begin
            mem[req.wr_addr].slot <= req.wr_data.slot;
        end
        if (req.wr_mask.free_h)
        begin
            mem[req.wr_addr].free_h <= req.wr_data.free_h;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/hsma_own_mem.sv
// Reverse map memory: the owning handle of every slot of every pool.
// One read and one write per cycle, registered read. Depends on hsma_pkg.
module hsma_own_mem (
    input  logic                             clk,
    input  hsma_pkg::own_req_t               req,
    output logic [hsma_pkg::HANDLE_W-1:0]    rd_data
);
    import hsma_pkg::*;

    logic [HANDLE_W-1:0] mem [NUM_KINDS * POOL_DEPTH];
    logic [HANDLE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/hsma_seq.sv
// Command sequencer: takes one word at a time, walks the read-modify-write
// steps on the two memories and holds the result. Depends on hsma_pkg.
module hsma_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    hsma_cmd_if.sink                      cmd,
    output hsma_pkg::tbl_req_t            tbl_req,
    input  hsma_pkg::tbl_row_t            tbl_rd,
    output hsma_pkg::own_req_t            own_req,
    input  logic [hsma_pkg::HANDLE_W-1:0] own_rd,
    output hsma_pkg::res_t                res,
    output logic                          res_valid,
    input  logic                          res_ready
);
    import hsma_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_POP  = 8'b0000_0010,
        S_ACQ  = 8'b0000_0100,
        S_ENT  = 8'b0000_1000,
        S_OWN  = 8'b0001_0000,
        S_KILL = 8'b0010_0000,
        S_PUSH = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [FUNC_W-1:0]   func_reg, func_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [KIND_W-1:0]   ekind_reg, ekind_next;
    logic [HANDLE_W-1:0] handle_reg, handle_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [HCNT_W-1:0]   created_reg, created_next;
    logic [HCNT_W-1:0]   free_cnt_reg, free_cnt_next;
    logic [FILL_W-1:0]   fill_reg [NUM_KINDS];
    logic [FILL_W-1:0]   fill_next [NUM_KINDS];
    res_t                res_reg, res_next;
    logic [FILL_W-1:0]   fill_sel;
    logic [SLOT_W-1:0]   acq_slot;

    function automatic res_t mk_res(status_t st, logic [HANDLE_W-1:0] h,
                                    logic [SLOT_W-1:0] s, logic [KIND_W-1:0] k);
        res_t r;
        r.status = st;
        r.handle = h;
        r.slot   = s;
        r.kind   = k;
        return r;
    endfunction

    assign cmd.ready = (state_reg == S_IDLE);
    assign res       = res_reg;

    always_comb
    begin
        state_next    = state_reg;
        func_next     = func_reg;
        kind_next     = kind_reg;
        ekind_next    = ekind_reg;
        handle_next   = handle_reg;
        slot_next     = slot_reg;
        created_next  = created_reg;
        free_cnt_next = free_cnt_reg;
        fill_next     = fill_reg;
        res_next      = res_reg;
        tbl_req       = '0;
        own_req       = '0;
        res_valid     = 1'b0;
        fill_sel      = fill_reg[cmd.shape_kind];
        acq_slot      = fill_reg[kind_reg][SLOT_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    func_next   = cmd.func;
                    kind_next   = cmd.shape_kind;
                    handle_next = cmd.handle;
                    case (cmd.func)
                        FN_ACQUIRE:
                        begin
                            if (fill_sel == FILL_W'(POOL_DEPTH))
                            begin
                                res_next   = mk_res(ST_FULL, '0, '0, '0);
                                state_next = S_OUT;
                            end
                            else if (free_cnt_reg != '0)
                            begin
                                // Reuse the most recently freed handle.
                                tbl_req.rd_en   = 1'b1;
                                tbl_req.rd_addr = HANDLE_W'(free_cnt_reg - 1'b1);
                                free_cnt_next   = free_cnt_reg - 1'b1;
                                state_next      = S_POP;
                            end
                            else if (created_reg != HCNT_W'(NUM_HANDLES))
                            begin
                                handle_next  = created_reg[HANDLE_W-1:0];
                                created_next = created_reg + 1'b1;
                                state_next   = S_ACQ;
                            end
                            else
                            begin
                                res_next   = mk_res(ST_NOHANDLE, '0, '0, '0);
                                state_next = S_OUT;
                            end
                        end
                        FN_LOOKUP, FN_DESTROY:
                        begin
                            if ({1'b0, cmd.handle} >= created_reg)
                            begin
                                res_next   = mk_res(ST_RANGE, cmd.handle, '0, '0);
                                state_next = S_OUT;
                            end
                            else
                            begin
                                tbl_req.rd_en   = 1'b1;
                                tbl_req.rd_addr = cmd.handle;
                                state_next      = S_ENT;
                            end
                        end
                        default:
                        begin
                            res_next   = mk_res(ST_BADKIND, cmd.handle, '0, '0);
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                handle_next = tbl_rd.free_h;
                state_next  = S_ACQ;
            end
            S_ACQ:
            begin
                tbl_req.wr_mask.live = 1'b1;
                tbl_req.wr_mask.kind = 1'b1;
                tbl_req.wr_mask.slot = 1'b1;
                tbl_req.wr_addr      = handle_reg;
                tbl_req.wr_data.live = 1'b1;
                tbl_req.wr_data.kind = kind_reg;
                tbl_req.wr_data.slot = acq_slot;
                own_req.wr_en        = 1'b1;
                own_req.wr_addr      = {kind_reg, acq_slot};
                own_req.wr_data      = handle_reg;
                fill_next[kind_reg]  = fill_reg[kind_reg] + 1'b1;
                res_next             = mk_res(ST_OK, handle_reg, acq_slot, kind_reg);
                state_next           = S_OUT;
            end
            S_ENT:
            begin
                if (!tbl_rd.live)
                begin
                    res_next   = mk_res(ST_DEAD, handle_reg, '0, tbl_rd.kind);
                    state_next = S_OUT;
                end
                else if (func_reg == FN_LOOKUP)
                begin
                    if (tbl_rd.kind != kind_reg)
                    begin
                        res_next = mk_res(ST_MISMATCH, handle_reg, '0, tbl_rd.kind);
                    end
                    else
                    begin
                        res_next = mk_res(ST_OK, handle_reg, tbl_rd.slot, kind_reg);
                    end
                    state_next = S_OUT;
                end
                else
                begin
                    // Fetch the owner of the pool's last slot.
                    slot_next       = tbl_rd.slot;
                    ekind_next      = tbl_rd.kind;
                    own_req.rd_en   = 1'b1;
                    own_req.rd_addr = {tbl_rd.kind,
                                       SLOT_W'(fill_reg[tbl_rd.kind] - 1'b1)};
                    state_next      = S_OWN;
                end
            end
            S_OWN:
            begin
                // Move the last slot into the hole and repoint both maps.
                tbl_req.wr_mask.slot = 1'b1;
                tbl_req.wr_addr      = own_rd;
                tbl_req.wr_data.slot = slot_reg;
                own_req.wr_en        = 1'b1;
                own_req.wr_addr      = {ekind_reg, slot_reg};
                own_req.wr_data      = own_rd;
                fill_next[ekind_reg] = fill_reg[ekind_reg] - 1'b1;
                state_next           = S_KILL;
            end
            S_KILL:
            begin
                tbl_req.wr_mask.live = 1'b1;
                tbl_req.wr_addr      = handle_reg;
                tbl_req.wr_data.live = 1'b0;
                state_next           = S_PUSH;
            end
            S_PUSH:
            begin
                tbl_req.wr_mask.free_h = 1'b1;
                tbl_req.wr_addr        = free_cnt_reg[HANDLE_W-1:0];
                tbl_req.wr_data.free_h = handle_reg;
                free_cnt_next          = free_cnt_reg + 1'b1;
                res_next               = mk_res(ST_OK, handle_reg, slot_reg, ekind_reg);
                state_next             = S_OUT;
            end
            S_OUT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            created_reg  <= '0;
            free_cnt_reg <= '0;
            for (int i = 0; i < NUM_KINDS; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            created_reg  <= created_next;
            free_cnt_reg <= free_cnt_next;
            fill_reg     <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        kind_reg   <= kind_next;
        ekind_reg  <= ekind_next;
        handle_reg <= handle_next;
        slot_reg   <= slot_next;
        res_reg    <= res_next;
    end

endmodule

>>> rtl/core/handle_slot_map_allocator.sv
// Top level of the handle slot map allocator: sequencer, two memories and
// the response register. Depends on hsma_pkg, hsma_cmd_if, hsma_rsp_if,
// hsma_tbl_mem, hsma_own_mem and hsma_seq.
//
// Usage: each word on cmd carries func (acquire, lookup, destroy), shape_kind
// and handle. Each accepted word yields exactly one word on rsp with status,
// handle_out, slot_offset and kind_out. Words are handled one at a time; cmd
// is ready only while the sequencer is idle.
// Steps per word: errors found from the counters (bad func, pool full, no
// handle, out of range) go straight to the response; lookup and a not-live
// handle read the table; acquire of a new handle writes the table and the
// reverse map; acquire that reuses a freed handle first pops the free stack.
// The rate is set by the handle table's single write port and registered read:
// destroy reads the table, reads the reverse map, then writes three table rows.
// The response appears on rsp in the same cycle that cmd is ready again.
// Reset clears the pool fill counts, the handle and free stack counts and
// the control state; no memory clearing pass is needed, so cmd is ready
// as soon as reset is released. When rsp stalls, the finished word waits in
// the response register and the sequencer holds its result until it can move.
module handle_slot_map_allocator (
    input logic      clk,
    input logic      rst_n,
    hsma_cmd_if.sink cmd,
    hsma_rsp_if.source rsp
);
    import hsma_pkg::*;

    tbl_req_t            tbl_req;
    tbl_row_t            tbl_rd;
    own_req_t            own_req;
    logic [HANDLE_W-1:0] own_rd;
    res_t                res;
    logic                res_valid;
    logic                res_ready;
    logic                out_valid_reg, out_valid_next;
    res_t                out_word_reg;

    hsma_tbl_mem u_tbl_mem (
        .clk     (clk),
        .req     (tbl_req),
        .rd_data (tbl_rd)
    );

    hsma_own_mem u_own_mem (
        .clk     (clk),
        .req     (own_req),
        .rd_data (own_rd)
    );

    hsma_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .tbl_req   (tbl_req),
        .tbl_rd    (tbl_rd),
        .own_req   (own_req),
        .own_rd    (own_rd),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (res_ready)
    );

    // The response register takes a new word when it is empty or drains now.
    assign res_ready = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_word_reg <= res;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_word_reg.status;
    assign rsp.handle_out  = out_word_reg.handle;
    assign rsp.slot_offset = out_word_reg.slot;
    assign rsp.kind_out    = out_word_reg.kind;

    // Only one word is in flight: an accept is never followed by another
    // accept on the next edge.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready |=> !cmd.ready)
        else $error("command accepted while previous word still in work");

    // A finished result never coexists with an open command port.
    a_result_blocks_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !cmd.ready)
        else $error("command port open while a result is pending");

    // Every error response reports slot zero.
    a_error_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status != ST_OK) |-> rsp.slot_offset == '0)
        else $error("error response with nonzero slot offset");

endmodule
